[hw/rtl/sorted_time_table_search_defines.svh]
// Assertion macros for the sorted time table search RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef SORTED_TIME_TABLE_SEARCH_DEFINES_SVH
`define SORTED_TIME_TABLE_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define STTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stts: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define STTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stts: next-cycle check failed");
`else
`define STTS_ASSERT_NOW(lbl, ante, cons)
`define STTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/stts_pkg.sv]
// Shared types and constants for the sorted time table search.
// No dependencies.
package stts_pkg;

  localparam int unsigned POS_W   = 11;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned KEY_W   = 64;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] entry_index;
    logic [KEY_W-1:0]  key_time;
  } stts_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             no_entries;
  } stts_out_t;

endpackage

[hw/rtl/sorted_time_table_search.sv]
// Sorted time table search: top level with the search sequencer.
// Depends on stts_pkg, stts_ram and sorted_time_table_search_defines.svh.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+-------------------------------
//   in_     | input     | in_valid / in_stall | stts_in_t (action, slot, key)
//   out_    | output    | out_valid/out_stall | stts_out_t (position, empty)
//   cfg_    | input     | cfg_valid/cfg_ready | entry_count, 11 bits
//
// Steps: a write word is stored as it is accepted. A search word is accepted
// while entry 0 is read (an empty table goes straight to emit), then runs the
// first-entry check, the last-entry check and the halving probes, any of which
// may end it, then the emit step. The single read port of the table memory gives one probe per cycle.
// Reset: synchronous, clears control state and entry_count; table contents
// stay undefined until written, so no clearing pass is needed.
// Stalls: in_stall stays high while a search runs; the result waits in the
// output register, and a finished search holds in its emit step until the
// output register is free.
`include "sorted_time_table_search_defines.svh"

module sorted_time_table_search
  import stts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ENTRY_BITS  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  stts_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output stts_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [POS_W-1:0]      count_r;           // configured entry count
  logic [POS_W-1:0]      cnt_r, cnt_nxt;    // saturated count latched per search
  logic [POS_W-1:0]      left_r, left_nxt;
  logic [POS_W-1:0]      right_r, right_nxt;
  logic [POS_W-1:0]      mid_r, mid_nxt;
  logic [ENTRY_BITS-1:0] key_r, key_nxt;
  logic [POS_W-1:0]      res_pos_r, res_pos_nxt;
  logic                  res_none_r, res_none_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stts_out_t             out_data_r, out_data_nxt;

  logic                  in_fire;
  logic [POS_W-1:0]      cnt_sat;
  logic [POS_W-1:0]      rd_pos;
  logic [31:0]           rd_pos_ext;
  logic [31:0]           slot_ext;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_en;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  key_lt;
  logic                  key_gt;
  logic [POS_W-1:0]      step_left;
  logic [POS_W-1:0]      step_right;
  logic [POS_W:0]        step_sum;
  logic [POS_W:0]        first_sum;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp the configured count to the table depth
  always_comb begin
    if (32'(count_r) > TABLE_DEPTH) begin
      cnt_sat = POS_W'(TABLE_DEPTH);
    end else begin
      cnt_sat = count_r;
    end
  end

  // map positions and slots onto memory addresses
  assign rd_pos_ext = 32'(rd_pos);
  assign rd_addr    = rd_pos_ext[ADDR_W-1:0];
  assign slot_ext   = 32'(in_data.entry_index);
  assign wr_addr    = slot_ext[ADDR_W-1:0];
  assign wr_en      = in_fire && (in_data.action == ACT_WRITE) && (slot_ext < TABLE_DEPTH);

  stts_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.key_time[ENTRY_BITS-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign key_lt = (key_r < rd_data);
  assign key_gt = (key_r > rd_data);

  // one halving step against the entry at mid
  always_comb begin
    if (key_lt) begin
      step_left  = left_r;
      step_right = mid_r;
    end else begin
      step_left  = mid_r + POS_W'(1);
      step_right = right_r;
    end
  end
  assign step_sum  = {1'b0, step_left} + {1'b0, step_right};
  assign first_sum = {1'b0, cnt_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_pos_nxt   = res_pos_r;
    res_none_nxt  = res_none_r;
    rd_pos        = mid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.action == ACT_SEARCH)) begin
          key_nxt = in_data.key_time[ENTRY_BITS-1:0];
          cnt_nxt = cnt_sat;
          if (cnt_sat == '0) begin
            res_pos_nxt  = '0;
            res_none_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            rd_pos    = '0;
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        res_none_nxt = 1'b0;
        if (key_lt) begin
          res_pos_nxt = '0;
          state_nxt   = S_EMIT;
        end else begin
          rd_pos    = cnt_r - POS_W'(1);
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (key_gt) begin
          res_pos_nxt = cnt_r;
          state_nxt   = S_EMIT;
        end else begin
          left_nxt  = '0;
          right_nxt = cnt_r;
          rd_pos    = first_sum[POS_W:1];
          mid_nxt   = first_sum[POS_W:1];
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!key_lt && !key_gt) begin
          res_pos_nxt = mid_r;
          state_nxt   = S_EMIT;
        end else if (step_left < step_right) begin
          left_nxt  = step_left;
          right_nxt = step_right;
          rd_pos    = step_sum[POS_W:1];
          mid_nxt   = step_sum[POS_W:1];
        end else begin
          res_pos_nxt = step_left;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.position   = res_pos_r;
          out_data_nxt.no_entries = res_none_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    res_pos_r  <= res_pos_nxt;
    res_none_r <= res_none_nxt;
    out_data_r <= out_data_nxt;
  end

  // a new result word only ever comes out of the emit step
  `STTS_ASSERT_NOW(a_rise_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT)
  // the probe window is never empty while probing
  `STTS_ASSERT_NOW(a_probe_window, state_r == S_PROBE, (left_r < right_r) && (right_r <= cnt_r))
  // the entry under test lies inside the window
  `STTS_ASSERT_NOW(a_mid_inside, state_r == S_PROBE, (mid_r >= left_r) && (mid_r < right_r))
  // a search always starts with the first-entry check or an empty-table result
  `STTS_ASSERT_NEXT(a_search_start, (state_r == S_IDLE) && in_valid && (in_data.action == ACT_SEARCH),
                    (state_r == S_FIRST) || (state_r == S_EMIT))

endmodule

[hw/rtl/stts_ram.sv]
// Simple dual-port table memory: one write port, one read port, registered read.
// No dependencies.
module stts_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
